// ===== src/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the Mandelbrot escape-time block
// Fixed-point widths, register indexes, reset values, queue and FSM types,
// and the clamp function for z.
package mbe_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int FIELD_W    = 12;
    localparam int CFG_W      = 32;
    localparam int ITER_W     = 8;
    localparam int IDX_W      = 3;

    // c = min + coord*step, carried exactly
    localparam int C_W   = CFG_W + COORD_BITS + 2;
    // z components are clamped to +-2.0
    localparam int Z_W   = FRAC_BITS + 3;
    localparam int P_W   = 2 * Z_W;
    localparam int SUM_W = ((C_W > P_W) ? C_W : P_W) + 2;
    localparam int ESC_W = P_W + 1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [IDX_W-1:0] REG_X_MIN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_MIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_STEP   = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic [CFG_W-1:0]  X_MIN_RST    = 32'hE800_0000;
    localparam logic [CFG_W-1:0]  Y_MIN_RST    = 32'hF800_0000;
    localparam logic [CFG_W-1:0]  STEP_RST     = 32'h0004_0000;
    localparam logic [ITER_W-1:0] MAX_ITER_RST = 8'd255;

    // |z|^2 escape bound: 4.0 at 2*FRAC_BITS fraction bits
    localparam logic [ESC_W-1:0] ESC_LIM =
        {{(ESC_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

    // clamp bound: 2.0 at FRAC_BITS fraction bits
    localparam logic signed [SUM_W-1:0] Z_LIM =
        {{(SUM_W-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
    localparam logic signed [SUM_W-1:0] Z_LIM_N = -Z_LIM;

    typedef struct packed {
        logic [CFG_W-1:0]  x_min;
        logic [CFG_W-1:0]  y_min;
        logic [CFG_W-1:0]  x_step;
        logic [CFG_W-1:0]  y_step;
        logic [ITER_W-1:0] max_iter;
    } cfg_t;

    typedef struct packed {
        logic [C_W-1:0] cx;
        logic [C_W-1:0] cy;
    } point_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_UPD,
        B_DONE
    } back_state_t;

    function automatic logic signed [Z_W-1:0] clamp_z(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        priority if (v > Z_LIM)
            r = Z_LIM;
        else if (v < Z_LIM_N)
            r = Z_LIM_N;
        else
            r = v;
        return r[Z_W-1:0];
    endfunction

endpackage

// ===== src/mbe_front.sv =====
// ----------------------------------------------------------------------------
// mbe_front: pixel intake
// Accepts a column/row item, maps it to the point c and hands it to the queue.
// ----------------------------------------------------------------------------
module mbe_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mbe_pkg::FIELD_W-1:0]      column,
    input  logic [mbe_pkg::FIELD_W-1:0]      row,
    input  mbe_pkg::cfg_t                    cfg,
    input  mbe_pkg::fifo_stat_t              fifo_stat,
    output logic                             push,
    output mbe_pkg::point_t                  push_data
);

    logic                                valid_reg;
    logic                                valid_next;
    mbe_pkg::point_t                     point_reg;
    logic                                accept;
    logic signed [mbe_pkg::COORD_BITS:0] col_s;
    logic signed [mbe_pkg::COORD_BITS:0] row_s;
    logic signed [mbe_pkg::C_W-1:0]      cx_calc;
    logic signed [mbe_pkg::C_W-1:0]      cy_calc;

    assign col_s = $signed({1'b0, column[mbe_pkg::COORD_BITS-1:0]});
    assign row_s = $signed({1'b0, row[mbe_pkg::COORD_BITS-1:0]});

    // exact in C_W bits: signed product plus sign-extended offset
    assign cx_calc = col_s * $signed(cfg.x_step) + $signed(cfg.x_min);
    assign cy_calc = row_s * $signed(cfg.y_step) + $signed(cfg.y_min);

    assign push      = valid_reg && !fifo_stat.full;
    assign in_stall  = valid_reg && fifo_stat.full;
    assign accept    = in_valid && !in_stall;
    assign push_data = point_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            point_reg.cx <= cx_calc;
            point_reg.cy <= cy_calc;
        end
    end

endmodule

// ===== src/mbe_fifo.sv =====
// ----------------------------------------------------------------------------
// mbe_fifo: point queue
// Short queue of mapped points between intake and iteration engine.
// ----------------------------------------------------------------------------
module mbe_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mbe_pkg::point_t     push_data,
    input  logic                pop,
    output mbe_pkg::point_t     pop_data,
    output mbe_pkg::fifo_stat_t stat
);

    mbe_pkg::point_t              mem_reg [mbe_pkg::FIFO_DEPTH];
    logic [mbe_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [mbe_pkg::FIFO_AW-1:0]  wr_ptr_next;
    logic [mbe_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [mbe_pkg::FIFO_AW-1:0]  rd_ptr_next;
    logic [mbe_pkg::FIFO_AW:0]    cnt_reg;
    logic [mbe_pkg::FIFO_AW:0]    cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign stat.full  = (cnt_reg == (mbe_pkg::FIFO_AW+1)'(mbe_pkg::FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + mbe_pkg::FIFO_AW'(1);
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + mbe_pkg::FIFO_AW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + (mbe_pkg::FIFO_AW+1)'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - (mbe_pkg::FIFO_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== src/mbe_back.sv =====
// ----------------------------------------------------------------------------
// mbe_back: escape-time iteration engine
// Runs z = z*z + c over a multiply stage and an update stage per step,
// then places the count in the output register.
// ----------------------------------------------------------------------------
module mbe_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mbe_pkg::cfg_t                  cfg,
    input  mbe_pkg::fifo_stat_t            fifo_stat,
    input  mbe_pkg::point_t                pop_data,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mbe_pkg::ITER_W-1:0]     iter_count
);

    typedef struct packed {
        logic pop;
        logic ld_prod;
        logic upd;
        logic ld_out;
    } back_ctl_t;

    mbe_pkg::back_state_t                state_reg;
    mbe_pkg::back_state_t                state_next;
    back_ctl_t                           ctl;

    logic signed [mbe_pkg::C_W-1:0]      cx_reg;
    logic signed [mbe_pkg::C_W-1:0]      cy_reg;
    logic signed [mbe_pkg::Z_W-1:0]      zx_reg;
    logic signed [mbe_pkg::Z_W-1:0]      zy_reg;
    logic [mbe_pkg::P_W-1:0]             sqx_reg;
    logic [mbe_pkg::P_W-1:0]             sqy_reg;
    logic signed [mbe_pkg::P_W-1:0]      xy_reg;
    logic [mbe_pkg::ITER_W-1:0]          n_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [mbe_pkg::ITER_W-1:0]          iter_reg;

    logic signed [mbe_pkg::P_W-1:0]      sqx_calc;
    logic signed [mbe_pkg::P_W-1:0]      sqy_calc;
    logic signed [mbe_pkg::P_W-1:0]      xy_calc;
    logic [mbe_pkg::ESC_W-1:0]           esc_sum;
    logic                                stop;
    logic                                out_free;
    logic [mbe_pkg::P_W-1:0]             sx;
    logic [mbe_pkg::P_W-1:0]             sy;
    logic signed [mbe_pkg::P_W-1:0]      pxy;
    logic signed [mbe_pkg::SUM_W-1:0]    x_new;
    logic signed [mbe_pkg::SUM_W-1:0]    y_new;

    assign sqx_calc = zx_reg * zx_reg;
    assign sqy_calc = zy_reg * zy_reg;
    assign xy_calc  = zx_reg * zy_reg;

    // squares are never negative, so the unsigned view is exact
    assign esc_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign stop    = (n_reg >= cfg.max_iter) || (esc_sum >= mbe_pkg::ESC_LIM);

    // floor division: logical shift for squares, arithmetic for 2*zx*zy
    assign sx  = sqx_reg >> mbe_pkg::FRAC_BITS;
    assign sy  = sqy_reg >> mbe_pkg::FRAC_BITS;
    assign pxy = xy_reg >>> (mbe_pkg::FRAC_BITS - 1);

    assign x_new = $signed({{(mbe_pkg::SUM_W-mbe_pkg::P_W){1'b0}}, sx})
                 - $signed({{(mbe_pkg::SUM_W-mbe_pkg::P_W){1'b0}}, sy})
                 + $signed({{(mbe_pkg::SUM_W-mbe_pkg::C_W){cx_reg[mbe_pkg::C_W-1]}}, cx_reg});
    assign y_new = $signed({{(mbe_pkg::SUM_W-mbe_pkg::P_W){pxy[mbe_pkg::P_W-1]}}, pxy})
                 + $signed({{(mbe_pkg::SUM_W-mbe_pkg::C_W){cy_reg[mbe_pkg::C_W-1]}}, cy_reg});

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbe_pkg::B_IDLE:
                if (!fifo_stat.empty)
                    state_next = mbe_pkg::B_MUL;
            mbe_pkg::B_MUL:
                state_next = mbe_pkg::B_UPD;
            mbe_pkg::B_UPD:
                state_next = stop ? mbe_pkg::B_DONE : mbe_pkg::B_MUL;
            mbe_pkg::B_DONE:
                if (out_free)
                    state_next = mbe_pkg::B_IDLE;
            default:
                state_next = mbe_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            mbe_pkg::B_IDLE: ctl.pop     = !fifo_stat.empty;
            mbe_pkg::B_MUL:  ctl.ld_prod = 1'b1;
            mbe_pkg::B_UPD:  ctl.upd     = !stop;
            mbe_pkg::B_DONE: ctl.ld_out  = out_free;
            default:         ctl         = '0;
        endcase
    end

    assign pop = ctl.pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.ld_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbe_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pop)
        begin
            cx_reg <= $signed(pop_data.cx);
            cy_reg <= $signed(pop_data.cy);
            zx_reg <= '0;
            zy_reg <= '0;
            n_reg  <= '0;
        end
        if (ctl.ld_prod)
        begin
            sqx_reg <= sqx_calc;
            sqy_reg <= sqy_calc;
            xy_reg  <= xy_calc;
        end
        if (ctl.upd)
        begin
            zx_reg <= mbe_pkg::clamp_z(x_new);
            zy_reg <= mbe_pkg::clamp_z(y_new);
            n_reg  <= n_reg + mbe_pkg::ITER_W'(1);
        end
        if (ctl.ld_out)
            iter_reg <= n_reg;
    end

    assign out_valid  = out_valid_reg;
    assign iter_count = iter_reg;

endmodule

// ===== src/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: per-pixel Mandelbrot escape-time counter
// Maps (column, row) to c, iterates z = z*z + c and returns the step count.
//
// Channels: input items (column, row) on in_valid/in_stall, result items
// (iter_count) on out_valid/out_stall; an item moves when valid is high and
// stall is low. Registers x_min, y_min, x_step, y_step, max_iter are written
// on the cfg port (index 0..4, other indexes ignored); cfg_ready is always
// high. Write registers only while no pixel is in flight.
// Each step passes through the complex multiply stage and then the add,
// clamp and escape-test stage of the iteration engine, which works on one
// pixel at a time. The intake and a two-entry point queue keep taking pixels
// while the engine works; in_stall rises only when both are full.
// Reset clears all control state and loads the register defaults
// (x_min -1.5, y_min -0.5, steps 2^-10, max_iter 255).
// While out_stall is high the result holds in the output register and the
// engine waits after finishing its next pixel.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mbe_pkg::FIELD_W-1:0]   column,
    input  logic [mbe_pkg::FIELD_W-1:0]   row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mbe_pkg::ITER_W-1:0]    iter_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbe_pkg::IDX_W-1:0]     cfg_index,
    input  logic [mbe_pkg::CFG_W-1:0]     cfg_data
);

    mbe_pkg::cfg_t       cfg_reg;
    mbe_pkg::cfg_t       cfg_next;
    mbe_pkg::fifo_stat_t fifo_stat;
    mbe_pkg::point_t     push_data;
    mbe_pkg::point_t     pop_data;
    logic                push;
    logic                pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbe_pkg::REG_X_MIN:    cfg_next.x_min    = cfg_data;
                mbe_pkg::REG_Y_MIN:    cfg_next.y_min    = cfg_data;
                mbe_pkg::REG_X_STEP:   cfg_next.x_step   = cfg_data;
                mbe_pkg::REG_Y_STEP:   cfg_next.y_step   = cfg_data;
                mbe_pkg::REG_MAX_ITER: cfg_next.max_iter = cfg_data[mbe_pkg::ITER_W-1:0];
                default:               cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min    <= mbe_pkg::X_MIN_RST;
            cfg_reg.y_min    <= mbe_pkg::Y_MIN_RST;
            cfg_reg.x_step   <= mbe_pkg::STEP_RST;
            cfg_reg.y_step   <= mbe_pkg::STEP_RST;
            cfg_reg.max_iter <= mbe_pkg::MAX_ITER_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    mbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .column    (column),
        .row       (row),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_data (push_data)
    );

    mbe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (fifo_stat)
    );

    mbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .fifo_stat  (fifo_stat),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .iter_count (iter_count)
    );

endmodule

// ===== src/mbe_checker.sv =====
// ----------------------------------------------------------------------------
// mbe_checker: port-level checks for mandelbrot_escape_time
// Watches the top-level handshakes; attached by bind.
// ----------------------------------------------------------------------------
module mbe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [mbe_pkg::ITER_W-1:0]    iter_count,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    // a stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(iter_count))
        else $error("result changed or dropped while stalled");

    // nothing is pending or blocked straight out of reset
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_stall && !out_valid)
        else $error("stall or result present right after reset");

    // intake only fills up after taking an item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("in_stall rose without an accepted item");

    // configuration port never pushes back
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write refused");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);
